// ===== hw/rtl/ugl_pkg.sv =====
// ----------------------------------------------------------------------------
// ugl_pkg: shared types and constants of the UTF-8 glyph layout block
// Holds the opcodes, the result kinds, the internal event record and the
// UTF-8 decode constants that the stages share.
// ----------------------------------------------------------------------------
package ugl_pkg;

  localparam int CMAP_DEPTH_DEF  = 1024;
  localparam int GLYPH_DEPTH_DEF = 256;

  // Replacement character for any encoding error.
  localparam logic [20:0] BAD_CP = 21'h00FFFD;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] LEAD4_BITS = 8'h07;

  typedef enum logic [1:0] {
    OP_TEXT   = 2'd0,
    OP_START  = 2'd1,
    OP_WCMAP  = 2'd2,
    OP_WGLYPH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_QUAD  = 2'd0,
    KIND_BLANK = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_GLYPH  = 3'd0,
    EV_FINISH = 3'd1,
    EV_START  = 3'd2,
    EV_WCMAP  = 3'd3,
    EV_WGLYPH = 3'd4
  } ev_kind_t;

  // One unit of work travelling down the pipeline.
  typedef struct packed {
    ev_kind_t    kind;
    logic [20:0] cp;
    logic        last;
    logic [15:0] start_x;
    logic [15:0] baseline_y;
    logic [9:0]  table_index;
    logic [15:0] glyph_number;
    logic [15:0] atlas_left;
    logic [15:0] atlas_top;
    logic [15:0] slot_width;
    logic [15:0] ink_height;
    logic [15:0] advance_width;
    logic [15:0] y_offset;
  } event_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] yoff;
  } glyph_place_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] adv;
  } glyph_size_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] code_point;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] quad_width;
    logic [15:0] quad_height;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic [15:0] text_width;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/ugl_in_if.sv =====
// ----------------------------------------------------------------------------
// ugl_in_if: input channel of the UTF-8 glyph layout block
// Valid/ready channel carrying one text byte, start or table write item.
// ----------------------------------------------------------------------------
interface ugl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         data_byte;
  logic signed [15:0] start_x;
  logic signed [15:0] baseline_y;
  logic [9:0]         table_index;
  logic [15:0]        glyph_number;
  logic [15:0]        atlas_left;
  logic [15:0]        atlas_top;
  logic signed [15:0] slot_width;
  logic signed [15:0] ink_height;
  logic signed [15:0] advance_width;
  logic signed [15:0] y_offset;

  modport source (
    output valid, opcode, data_byte, start_x, baseline_y, table_index, glyph_number,
           atlas_left, atlas_top, slot_width, ink_height, advance_width, y_offset,
    input  ready
  );

  modport sink (
    input  valid, opcode, data_byte, start_x, baseline_y, table_index, glyph_number,
           atlas_left, atlas_top, slot_width, ink_height, advance_width, y_offset,
    output ready
  );
endinterface

// ===== hw/rtl/ugl_out_if.sv =====
// ----------------------------------------------------------------------------
// ugl_out_if: result channel of the UTF-8 glyph layout block
// Valid/ready channel carrying one quad, blank advance or end-of-string item.
// ----------------------------------------------------------------------------
interface ugl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [20:0]        code_point;
  logic [15:0]        src_x;
  logic [15:0]        src_y;
  logic signed [15:0] quad_width;
  logic signed [15:0] quad_height;
  logic signed [15:0] dst_x;
  logic signed [15:0] dst_y;
  logic signed [15:0] text_width;
  logic               last;

  modport source (
    output valid, kind, code_point, src_x, src_y, quad_width, quad_height, dst_x, dst_y,
           text_width, last,
    input  ready
  );

  modport sink (
    input  valid, kind, code_point, src_x, src_y, quad_width, quad_height, dst_x, dst_y,
           text_width, last,
    output ready
  );
endinterface

// ===== hw/rtl/ugl_decode.sv =====
// ----------------------------------------------------------------------------
// ugl_decode: UTF-8 decoder front end
// Accepts input items, tracks the open string and any pending multi-byte
// sequence, and issues one pipeline event per cycle into a free register.
// ----------------------------------------------------------------------------
module ugl_decode (
  input  logic            clk,
  input  logic            rst_n,
  ugl_in_if.sink          in_ch,
  output logic            a_valid,
  output ugl_pkg::event_t a_ev,
  input  logic            a_ready
);

  logic            a_valid_r;
  ugl_pkg::event_t a_ev_r;
  ugl_pkg::event_t ev2_r;
  logic            pend2_r;
  logic            active_r, active_nxt;
  logic [1:0]      bl_r, bl_nxt;
  logic [20:0]     pc_r, pc_nxt;
  logic            a_load;
  logic            accept;
  logic [7:0]      b;

  logic            lead_emit;
  logic            lead_fin;
  logic [20:0]     lead_cp;
  logic [20:0]     lead_pc;
  logic [1:0]      lead_bl;
  logic            take_lead;
  logic [20:0]     cont_pc;
  logic [1:0]      bl_dec;

  ugl_pkg::event_t ev_base, ev_new, ev_second;
  logic            ev_new_v, second_v;

  assign b = in_ch.data_byte;

  // Decode of a byte taken as a lead byte.
  always_comb begin
    lead_emit = 1'b1;
    lead_fin  = 1'b0;
    lead_cp   = ugl_pkg::BAD_CP;
    lead_pc   = '0;
    lead_bl   = 2'd0;
    if (b == 8'h00) begin
      lead_fin = 1'b1;
      lead_cp  = '0;
    end else if (!b[7]) begin
      lead_cp = {13'd0, b};
    end else if ((b & ugl_pkg::LEAD2_MASK) == ugl_pkg::LEAD2_TAG) begin
      lead_emit = 1'b0;
      lead_pc   = {13'd0, b & ugl_pkg::LEAD2_BITS};
      lead_bl   = 2'd1;
    end else if ((b & ugl_pkg::LEAD3_MASK) == ugl_pkg::LEAD3_TAG) begin
      lead_emit = 1'b0;
      lead_pc   = {13'd0, b & ugl_pkg::LEAD3_BITS};
      lead_bl   = 2'd2;
    end else if ((b & ugl_pkg::LEAD4_MASK) == ugl_pkg::LEAD4_TAG) begin
      lead_emit = 1'b0;
      lead_pc   = {13'd0, b & ugl_pkg::LEAD4_BITS};
      lead_bl   = 2'd3;
    end
  end

  always_comb begin
    ev_base               = '0;
    ev_base.kind          = ugl_pkg::EV_GLYPH;
    ev_base.last          = 1'b1;
    ev_base.start_x       = $unsigned(in_ch.start_x);
    ev_base.baseline_y    = $unsigned(in_ch.baseline_y);
    ev_base.table_index   = in_ch.table_index;
    ev_base.glyph_number  = in_ch.glyph_number;
    ev_base.atlas_left    = in_ch.atlas_left;
    ev_base.atlas_top     = in_ch.atlas_top;
    ev_base.slot_width    = $unsigned(in_ch.slot_width);
    ev_base.ink_height    = $unsigned(in_ch.ink_height);
    ev_base.advance_width = $unsigned(in_ch.advance_width);
    ev_base.y_offset      = $unsigned(in_ch.y_offset);
  end

  always_comb begin
    ev_new     = ev_base;
    ev_second  = ev_base;
    ev_new_v   = 1'b0;
    second_v   = 1'b0;
    take_lead  = 1'b0;
    active_nxt = active_r;
    bl_nxt     = bl_r;
    pc_nxt     = pc_r;
    cont_pc    = {pc_r[14:0], b[5:0]};
    bl_dec     = bl_r - 2'd1;
    unique case (ugl_pkg::opcode_t'(in_ch.opcode))
      ugl_pkg::OP_START: begin
        ev_new.kind = ugl_pkg::EV_START;
        ev_new_v    = 1'b1;
        active_nxt  = 1'b1;
        bl_nxt      = 2'd0;
        pc_nxt      = '0;
      end
      ugl_pkg::OP_WCMAP: begin
        ev_new.kind = ugl_pkg::EV_WCMAP;
        ev_new_v    = 1'b1;
      end
      ugl_pkg::OP_WGLYPH: begin
        ev_new.kind = ugl_pkg::EV_WGLYPH;
        ev_new_v    = 1'b1;
      end
      ugl_pkg::OP_TEXT: begin
        if (active_r) begin
          if (bl_r == 2'd0) begin
            ev_new.kind = lead_fin ? ugl_pkg::EV_FINISH : ugl_pkg::EV_GLYPH;
            ev_new.cp   = lead_cp;
            ev_new_v    = lead_emit;
            take_lead   = 1'b1;
          end else if ((b & ugl_pkg::CONT_MASK) == ugl_pkg::CONT_TAG) begin
            bl_nxt = bl_dec;
            if (bl_dec != 2'd0) begin
              pc_nxt = cont_pc;
            end else if (cont_pc == '0) begin
              ev_new.kind = ugl_pkg::EV_FINISH;
              ev_new_v    = 1'b1;
              active_nxt  = 1'b0;
              pc_nxt      = '0;
            end else begin
              ev_new.cp = cont_pc;
              ev_new_v  = 1'b1;
              pc_nxt    = '0;
            end
          end else begin
            // The broken sequence yields a replacement glyph, then the same
            // byte starts over as a lead byte.
            ev_new.cp      = ugl_pkg::BAD_CP;
            ev_new.last    = !lead_emit;
            ev_new_v       = 1'b1;
            ev_second.kind = lead_fin ? ugl_pkg::EV_FINISH : ugl_pkg::EV_GLYPH;
            ev_second.cp   = lead_cp;
            second_v       = lead_emit;
            take_lead      = 1'b1;
          end
          if (take_lead) begin
            if (lead_fin) begin
              active_nxt = 1'b0;
              bl_nxt     = 2'd0;
              pc_nxt     = '0;
            end else if (!lead_emit) begin
              bl_nxt = lead_bl;
              pc_nxt = lead_pc;
            end else begin
              bl_nxt = 2'd0;
              pc_nxt = '0;
            end
          end
        end
      end
    endcase
  end

  assign a_load      = !a_valid_r || a_ready;
  assign in_ch.ready = a_load && !pend2_r;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      pend2_r   <= 1'b0;
      active_r  <= 1'b0;
      bl_r      <= 2'd0;
      pc_r      <= '0;
    end else begin
      if (a_load) begin
        if (pend2_r) begin
          a_valid_r <= 1'b1;
          pend2_r   <= 1'b0;
        end else begin
          a_valid_r <= accept && ev_new_v;
          pend2_r   <= accept && second_v;
        end
      end
      if (accept) begin
        active_r <= active_nxt;
        bl_r     <= bl_nxt;
        pc_r     <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_ev_r <= pend2_r ? ev2_r : ev_new;
    end
    if (accept) begin
      ev2_r <= ev_second;
    end
  end

  assign a_valid = a_valid_r;
  assign a_ev    = a_ev_r;

  a_seq_needs_string: assert property (@(posedge clk) disable iff (!rst_n)
    (bl_r != 2'd0) |-> active_r)
    else $error("pending UTF-8 sequence without an open string");

  a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    pend2_r |-> a_valid_r)
    else $error("second event pending with no first event in the stage");

  a_first_is_bad_cp: assert property (@(posedge clk) disable iff (!rst_n)
    pend2_r |-> (!a_ev_r.last && a_ev_r.cp == ugl_pkg::BAD_CP))
    else $error("first of two events is not a non-final replacement glyph");

endmodule

// ===== hw/rtl/ugl_tables.sv =====
// ----------------------------------------------------------------------------
// ugl_tables: cmap and glyph table stages
// Two pipeline stages around the cmap memory and the glyph memories. Table
// writes travel in order with the lookups and write at the stage that reads.
// ----------------------------------------------------------------------------
module ugl_tables #(
  parameter int CMAP_DEPTH  = ugl_pkg::CMAP_DEPTH_DEF,
  parameter int GLYPH_DEPTH = ugl_pkg::GLYPH_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [10:0]           cmap_size,
  input  logic [8:0]            glyph_count,
  input  logic                  a_valid,
  input  ugl_pkg::event_t       a_ev,
  output logic                  a_ready,
  output logic                  c_valid,
  output ugl_pkg::event_t       c_ev,
  output ugl_pkg::glyph_place_t c_place,
  output ugl_pkg::glyph_size_t  c_size,
  input  logic                  c_ready
);

  localparam int CA = (CMAP_DEPTH > 1) ? $clog2(CMAP_DEPTH) : 1;
  localparam int GA = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam logic [31:0] CMAP_DEPTH_W  = 32'(CMAP_DEPTH);
  localparam logic [31:0] GLYPH_DEPTH_W = 32'(GLYPH_DEPTH);

  logic [15:0]           cmap_mem  [CMAP_DEPTH];
  ugl_pkg::glyph_place_t place_mem [GLYPH_DEPTH];
  ugl_pkg::glyph_size_t  size_mem  [GLYPH_DEPTH];

  logic                  b_valid_r;
  ugl_pkg::event_t       b_ev_r;
  logic                  b_hit_r;
  logic [15:0]           cmap_rd_r;
  logic                  c_valid_r;
  ugl_pkg::event_t       c_ev_r;
  ugl_pkg::glyph_place_t place_rd_r;
  ugl_pkg::glyph_size_t  size_rd_r;

  logic        en_b, en_c;
  logic [31:0] csz_w, gcnt_w, cp_w, a_idx_w, b_idx_w, gi_w;
  logic        hit;
  logic        cmap_we, glyph_we;
  logic [CA-1:0] cmap_waddr, cmap_raddr;
  logic [GA-1:0] glyph_waddr, glyph_raddr;

  assign en_c    = !c_valid_r || c_ready;
  assign en_b    = !b_valid_r || en_c;
  assign a_ready = en_b;

  // Effective table sizes are clipped to the physical depths.
  assign csz_w  = (32'(cmap_size) < CMAP_DEPTH_W) ? 32'(cmap_size) : CMAP_DEPTH_W;
  assign gcnt_w = (32'(glyph_count) < GLYPH_DEPTH_W) ? 32'(glyph_count) : GLYPH_DEPTH_W;

  assign cp_w       = 32'(a_ev.cp);
  assign hit        = cp_w < csz_w;
  assign cmap_raddr = cp_w[CA-1:0];
  assign a_idx_w    = 32'(a_ev.table_index);
  assign cmap_waddr = a_idx_w[CA-1:0];
  assign cmap_we    = en_b && a_valid && (a_ev.kind == ugl_pkg::EV_WCMAP) &&
                      (a_idx_w < CMAP_DEPTH_W);

  // A miss in the cmap or a glyph index past the count both fall back to glyph 0.
  assign gi_w        = (b_hit_r && (32'(cmap_rd_r) < gcnt_w)) ? 32'(cmap_rd_r) : 32'd0;
  assign glyph_raddr = gi_w[GA-1:0];
  assign b_idx_w     = 32'(b_ev_r.table_index);
  assign glyph_waddr = b_idx_w[GA-1:0];
  assign glyph_we    = en_c && b_valid_r && (b_ev_r.kind == ugl_pkg::EV_WGLYPH) &&
                       (b_idx_w < GLYPH_DEPTH_W);

  always_ff @(posedge clk) begin
    if (cmap_we) begin
      cmap_mem[cmap_waddr] <= b_ev_w_glyph_number(a_ev);
    end
    if (en_b) begin
      cmap_rd_r <= cmap_mem[cmap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      place_mem[glyph_waddr] <= {b_ev_r.atlas_left, b_ev_r.atlas_top, b_ev_r.y_offset};
      size_mem[glyph_waddr]  <= {b_ev_r.slot_width, b_ev_r.ink_height, b_ev_r.advance_width};
    end
    if (en_c) begin
      place_rd_r <= place_mem[glyph_raddr];
      size_rd_r  <= size_mem[glyph_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (en_b) begin
        b_valid_r <= a_valid;
      end
      if (en_c) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_ev_r  <= a_ev;
      b_hit_r <= hit;
    end
    if (en_c) begin
      c_ev_r <= b_ev_r;
    end
  end

  function automatic logic [15:0] b_ev_w_glyph_number(input ugl_pkg::event_t ev);
    return ev.glyph_number;
  endfunction

  assign c_valid = c_valid_r;
  assign c_ev    = c_ev_r;
  assign c_place = place_rd_r;
  assign c_size  = size_rd_r;

endmodule

// ===== hw/rtl/ugl_layout.sv =====
// ----------------------------------------------------------------------------
// ugl_layout: pen tracking and result register
// Applies the glyph metrics to the pen, builds the result item and holds it
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module ugl_layout (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  c_valid,
  input  ugl_pkg::event_t       c_ev,
  input  ugl_pkg::glyph_place_t c_place,
  input  ugl_pkg::glyph_size_t  c_size,
  output logic                  c_ready,
  ugl_out_if.source             out_ch
);

  logic             out_valid_r;
  ugl_pkg::result_t res_r, res_nxt;
  logic [15:0]      pen_r, pen_nxt;
  logic [15:0]      origin_r, origin_nxt;
  logic [15:0]      base_r, base_nxt;
  logic             produce;
  logic             ink;
  logic [15:0]      pen_adv;
  logic             consume;

  assign c_ready = !out_valid_r || out_ch.ready;
  assign consume = c_valid && c_ready;

  // A glyph has ink only when both width and height are strictly positive.
  assign ink     = (c_size.w != 16'd0) && !c_size.w[15] &&
                   (c_size.h != 16'd0) && !c_size.h[15];
  assign pen_adv = pen_r + c_size.adv;

  always_comb begin
    res_nxt      = '0;
    res_nxt.last = c_ev.last;
    produce      = 1'b0;
    pen_nxt      = pen_r;
    origin_nxt   = origin_r;
    base_nxt     = base_r;
    case (c_ev.kind)
      ugl_pkg::EV_GLYPH: begin
        produce            = 1'b1;
        pen_nxt            = pen_adv;
        res_nxt.code_point = c_ev.cp;
        res_nxt.dst_x      = pen_r;
        res_nxt.text_width = pen_adv - origin_r;
        if (ink) begin
          res_nxt.kind        = ugl_pkg::KIND_QUAD;
          res_nxt.src_x       = c_place.left;
          res_nxt.src_y       = c_place.top;
          res_nxt.quad_width  = c_size.w;
          res_nxt.quad_height = c_size.h;
          res_nxt.dst_y       = base_r + c_place.yoff;
        end else begin
          res_nxt.kind = ugl_pkg::KIND_BLANK;
        end
      end
      ugl_pkg::EV_FINISH: begin
        produce            = 1'b1;
        res_nxt.kind       = ugl_pkg::KIND_END;
        res_nxt.text_width = pen_r - origin_r;
      end
      ugl_pkg::EV_START: begin
        pen_nxt    = c_ev.start_x;
        origin_nxt = c_ev.start_x;
        base_nxt   = c_ev.baseline_y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pen_r       <= '0;
      origin_r    <= '0;
      base_r      <= '0;
    end else begin
      if (c_ready) begin
        out_valid_r <= c_valid && produce;
      end
      if (consume) begin
        pen_r    <= pen_nxt;
        origin_r <= origin_nxt;
        base_r   <= base_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && produce) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.code_point  = res_r.code_point;
  assign out_ch.src_x       = res_r.src_x;
  assign out_ch.src_y       = res_r.src_y;
  assign out_ch.quad_width  = $signed(res_r.quad_width);
  assign out_ch.quad_height = $signed(res_r.quad_height);
  assign out_ch.dst_x       = $signed(res_r.dst_x);
  assign out_ch.dst_y       = $signed(res_r.dst_y);
  assign out_ch.text_width  = $signed(res_r.text_width);
  assign out_ch.last        = res_r.last;

  a_end_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == ugl_pkg::KIND_END) |->
      (res_r.last && res_r.dst_x == 16'd0 && res_r.code_point == 21'd0))
    else $error("end-of-string item is not final or carries position data");

  a_blank_no_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind == ugl_pkg::KIND_BLANK) |->
      (res_r.quad_width == 16'd0 && res_r.quad_height == 16'd0 && res_r.dst_y == 16'd0))
    else $error("blank advance item carries a rectangle");

endmodule

// ===== hw/rtl/utf8_glyph_layout.sv =====
// ----------------------------------------------------------------------------
// utf8_glyph_layout: UTF-8 text layout against a bitmap font
// Decodes a UTF-8 byte stream, maps code points through a cmap and a glyph
// table held in on-chip memories, and emits one placed quad or blank advance per glyph.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: a start item that opens a string and
//   sets the pen x and baseline, table writes for the cmap and glyph stores,
//   or one UTF-8 text byte. out_ch carries glyph quads, blank advances and the
//   end-of-string item with the total width. cfg_* is an APB write/read port
//   for cmap_size (address 0) and glyph_count (address 4); write it only while
//   the block is idle.
//   Throughput is one input item per cycle when nothing stalls. A broken
//   continuation byte whose byte also yields a result of its own as a lead
//   byte holds the decoder until both results are out; the decoder issues one
//   event per cycle while a_ready is high. An accepted text byte reaches out_ch
//   via decode register, cmap memory read, glyph memory read, output register.
//   Reset empties the pipeline, closes any open string, and sets cmap_size to 0
//   and glyph_count to 1. The table memories hold nothing defined until written.
//   When the receiver stalls, the result stays in the output register and the
//   stages behind it keep filling; in_ch.ready drops once all of them are full.
// ----------------------------------------------------------------------------
module utf8_glyph_layout #(
  parameter int CMAP_DEPTH  = ugl_pkg::CMAP_DEPTH_DEF,
  parameter int GLYPH_DEPTH = ugl_pkg::GLYPH_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ugl_in_if.sink      in_ch,
  ugl_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Register select is address bit 2: one 32-bit register per word.
  localparam logic REG_CMAP_SIZE   = 1'b0;
  localparam logic REG_GLYPH_COUNT = 1'b1;

  logic [10:0] cmap_size_r;
  logic [8:0]  glyph_count_r;
  logic        cfg_wr;

  logic                  a_valid, a_ready;
  ugl_pkg::event_t       a_ev;
  logic                  c_valid, c_ready;
  ugl_pkg::event_t       c_ev;
  ugl_pkg::glyph_place_t c_place;
  ugl_pkg::glyph_size_t  c_size;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmap_size_r   <= 11'd0;
      glyph_count_r <= 9'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_CMAP_SIZE:   cmap_size_r   <= cfg_pwdata[10:0];
        REG_GLYPH_COUNT: glyph_count_r <= cfg_pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CMAP_SIZE:   cfg_prdata = {21'd0, cmap_size_r};
      REG_GLYPH_COUNT: cfg_prdata = {23'd0, glyph_count_r};
    endcase
  end

  // UTF-8 decode: one event per cycle into the table pipeline unless stalled.
  ugl_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .a_valid (a_valid),
    .a_ev    (a_ev),
    .a_ready (a_ready)
  );

  // Cmap lookup followed by the dependent glyph table lookup.
  ugl_tables #(
    .CMAP_DEPTH  (CMAP_DEPTH),
    .GLYPH_DEPTH (GLYPH_DEPTH)
  ) u_tables (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmap_size   (cmap_size_r),
    .glyph_count (glyph_count_r),
    .a_valid     (a_valid),
    .a_ev        (a_ev),
    .a_ready     (a_ready),
    .c_valid     (c_valid),
    .c_ev        (c_ev),
    .c_place     (c_place),
    .c_size      (c_size),
    .c_ready     (c_ready)
  );

  // Pen arithmetic and the output register.
  ugl_layout u_layout (
    .clk     (clk),
    .rst_n   (rst_n),
    .c_valid (c_valid),
    .c_ev    (c_ev),
    .c_place (c_place),
    .c_size  (c_size),
    .c_ready (c_ready),
    .out_ch  (out_ch)
  );

endmodule
